// ----- sv/tmnp_pkg.sv -----
// shared constants, types, coefficient rom and rounding helper for the tof pid pipeline
`timescale 1ns / 1ps
package tmnp_pkg;

   localparam int M2_W      = 16;
   localparam int MOM_W     = 16;
   localparam int SCORE_W   = 16;
   localparam int NSPEC     = 3;
   localparam int NARM      = 2;
   localparam int COEF_W    = 19;
   localparam int LN_W      = 22;
   localparam int BPROD_W   = 36;
   localparam int DPROD_W   = 41;
   localparam int TERM_W    = 24;
   localparam int PART_W    = 25;
   localparam int DIFF_W    = 17;
   localparam int SIGMA_W   = 34;
   localparam int NUM1_W    = 32;
   localparam int NUM2_W    = 33;
   localparam int DEN2_W    = 32;
   localparam int RND_W     = 48;
   localparam int MOM_FRAC  = 13;
   localparam int LN2_Q16   = 45426;
   localparam int SCORE_MAX = 32767;
   localparam int SCORE_MIN_MAG = 32768;

   typedef logic signed [COEF_W-1:0] coef_type;

   typedef struct packed {
      coef_type a;
      coef_type b;
      coef_type c;
      coef_type d;
   } coef_set_type;

   // [arm][species], q.20; species pion, kaon, proton
   localparam coef_set_type COEF_ROM [NARM][NSPEC] = '{
      '{ '{-31521, 45638, -157, -19926},
         '{-39008, 86403, -23662, -80824},
         '{-67111, -8347, 136477, 155604} },
      '{ '{-47581, 83701, -17019, -64510},
         '{-76935, 156011, -53900, -172104},
         '{-69747, 125439, 9509, -119654} }
   };

   localparam logic signed [DIFF_W-1:0] M2_EXP [NSPEC] = '{80, 998, 3604};

   // ln(1 + i/16) in q.16
   localparam logic [15:0] LN_TABLE [17] = '{
      16'd0, 16'd3973, 16'd7719, 16'd11262, 16'd14624, 16'd17821, 16'd20870,
      16'd23783, 16'd26573, 16'd29248, 16'd31818, 16'd34292, 16'd36675,
      16'd38975, 16'd41196, 16'd43345, 16'd45426
   };

   typedef struct packed {
      logic                       zero;
      logic                       neg_c;
      logic signed [DIFF_W-1:0]   diff;
      logic signed [PART_W-1:0]   partial;
   } div1_side_type;

   typedef struct packed {
      logic bad;
      logic neg;
   } div2_side_type;

   // arithmetic shift right with rounding to nearest, halves away from zero
   function automatic logic signed [RND_W-1:0] round_shr(
      input logic signed [RND_W-1:0] x,
      input int                      n
   );
      logic [RND_W-1:0] mag;
      logic [RND_W-1:0] r;
      mag = x[RND_W-1] ? RND_W'(-x) : RND_W'(x);
      r = (mag + (RND_W'(1) << (n - 1))) >> n;
      return x[RND_W-1] ? $signed(-r) : $signed(r);
   endfunction

endpackage

// ----- sv/tof_mass_nsigma_pid.sv -----
// top level: tof n-sigma scores for pion, kaon and proton hypotheses
// throughput: one transaction per cycle while the output is not stalled; the two bit-per-stage dividers
// (32 and 33 stages per species) set the depth
// the whole pipeline holds while rsp_tvalid is high and rsp_tready low
// reset (synchronous, active high) clears all valid bits; data regs are not reset
`timescale 1ns / 1ps
module tof_mass_nsigma_pid (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // m2_tof[15:0], momentum[31:16]
   input  logic        req_tuser,   // arm[0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // pion_score[15:0], kaon_score[31:16], proton_score[47:32]
   output logic [2:0]  rsp_tuser    // bad_mask[2:0]
);
   import tmnp_pkg::*;

   localparam int SIDE1_W = $bits(div1_side_type);
   localparam int SIDE2_W = $bits(div2_side_type);

   logic en;

   // stage 1: input capture
   logic                     v1_ff;
   logic signed [M2_W-1:0]   m2_1_ff;
   logic [MOM_W-1:0]         mom_1_ff;
   logic                     arm_1_ff;

   // stage 2
   logic                       v2_ff, arm_2_ff;
   logic signed [M2_W-1:0]     m2_2_ff;
   logic [MOM_W-1:0]           mom_2_ff;
   logic signed [BPROD_W-1:0]  bprod_in [NSPEC];
   logic signed [BPROD_W-1:0]  bprod_ff [NSPEC];

   // stage 3
   logic                       v3_ff, arm_3_ff;
   logic signed [M2_W-1:0]     m2_3_ff;
   logic [MOM_W-1:0]           mom_3_ff;
   logic signed [TERM_W-1:0]   bterm_in [NSPEC];
   logic signed [TERM_W-1:0]   bterm_ff [NSPEC];
   logic signed [LN_W-1:0]     ln;

   // stage 4
   logic                       v4_ff, arm_4_ff;
   logic signed [M2_W-1:0]     m2_4_ff;
   logic [MOM_W-1:0]           mom_4_ff;
   logic signed [TERM_W-1:0]   bterm_4_ff [NSPEC];
   logic signed [DPROD_W-1:0]  dprod_in [NSPEC];
   logic signed [DPROD_W-1:0]  dprod_ff [NSPEC];

   // stage 5
   logic                       v5_ff, arm_5_ff;
   logic signed [M2_W-1:0]     m2_5_ff;
   logic [MOM_W-1:0]           mom_5_ff;
   logic signed [PART_W-1:0]   part_in [NSPEC];
   logic signed [PART_W-1:0]   part_ff [NSPEC];

   // first divider: c / pt
   logic [NUM1_W-1:0]   num1  [NSPEC];
   div1_side_type       side1 [NSPEC];
   logic [NUM1_W-1:0]   q1    [NSPEC];
   logic [SIDE1_W-1:0]  side1_out [NSPEC];
   logic                v1out [NSPEC];

   // stage 6: sigma
   logic                       v6_ff;
   logic signed [SIGMA_W-1:0]  sigma_in [NSPEC];
   logic signed [SIGMA_W-1:0]  sigma_ff [NSPEC];
   logic signed [DIFF_W-1:0]   diff_6_ff [NSPEC];
   logic                       zero_6_ff [NSPEC];

   // stage 7: score divider operands
   logic                       v7_ff;
   logic [NUM2_W-1:0]          num2_in [NSPEC];
   logic [NUM2_W-1:0]          num2_ff [NSPEC];
   logic [DEN2_W-1:0]          den2_ff [NSPEC];
   div2_side_type              side2_in [NSPEC];
   div2_side_type              side2_ff [NSPEC];

   // second divider
   logic [NUM2_W-1:0]   q2 [NSPEC];
   logic [SIDE2_W-1:0]  side2_out [NSPEC];
   logic                v2out [NSPEC];

   // stage 8: output
   logic                        rsp_valid_ff;
   logic signed [SCORE_W-1:0]   score_in [NSPEC];
   logic signed [SCORE_W-1:0]   score_ff [NSPEC];
   logic [NSPEC-1:0]            bad_in, bad_ff;

   assign en         = !rsp_valid_ff || rsp_tready;
   assign req_tready = en;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
         v7_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= req_tvalid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
         v6_ff <= v1out[0] && v1out[1] && v1out[2];
         v7_ff <= v6_ff;
         rsp_valid_ff <= v2out[0] && v2out[1] && v2out[2];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         m2_1_ff  <= $signed(req_tdata[15:0]);
         mom_1_ff <= req_tdata[31:16];
         arm_1_ff <= req_tuser;
         m2_2_ff  <= m2_1_ff;
         mom_2_ff <= mom_1_ff;
         arm_2_ff <= arm_1_ff;
         m2_3_ff  <= m2_2_ff;
         mom_3_ff <= mom_2_ff;
         arm_3_ff <= arm_2_ff;
         m2_4_ff  <= m2_3_ff;
         mom_4_ff <= mom_3_ff;
         arm_4_ff <= arm_3_ff;
         m2_5_ff  <= m2_4_ff;
         mom_5_ff <= mom_4_ff;
         arm_5_ff <= arm_4_ff;
      end
   end

   tmnp_ln u_ln (
      .clock (clock),
      .en    (en),
      .mom   (mom_1_ff),
      .ln    (ln)
   );

   always_comb begin
      for (int s = 0; s < NSPEC; s++) begin
         bprod_in[s] = COEF_ROM[arm_1_ff][s].b * $signed({1'b0, mom_1_ff});
         bterm_in[s] = TERM_W'(round_shr(RND_W'(bprod_ff[s]), MOM_FRAC));
         dprod_in[s] = COEF_ROM[arm_3_ff][s].d * ln;
         part_in[s]  = PART_W'(COEF_ROM[arm_4_ff][s].a) + PART_W'(bterm_4_ff[s])
                     + PART_W'(round_shr(RND_W'(dprod_ff[s]), 16));
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int s = 0; s < NSPEC; s++) begin
            bprod_ff[s]   <= bprod_in[s];
            bterm_ff[s]   <= bterm_in[s];
            bterm_4_ff[s] <= bterm_ff[s];
            dprod_ff[s]   <= dprod_in[s];
            part_ff[s]    <= part_in[s];
         end
      end
   end

   // c/pt operands: magnitude of c shifted by the pt fraction, plus half divisor
   always_comb begin
      for (int s = 0; s < NSPEC; s++) begin
         coef_type cc;
         logic [COEF_W-1:0] cabs;
         cc = COEF_ROM[arm_5_ff][s].c;
         cabs = cc[COEF_W-1] ? COEF_W'(-cc) : COEF_W'(cc);
         num1[s] = NUM1_W'({cabs, 13'b0}) + NUM1_W'(mom_5_ff >> 1);
         side1[s].zero    = (mom_5_ff == '0);
         side1[s].neg_c   = cc[COEF_W-1];
         side1[s].diff    = $signed({m2_5_ff[M2_W-1], m2_5_ff}) - M2_EXP[s];
         side1[s].partial = part_ff[s];
      end
   end

   for (genvar s = 0; s < NSPEC; s++) begin : g_div1
      tmnp_div #(
         .NUM_W  (NUM1_W),
         .DEN_W  (MOM_W),
         .SIDE_W (SIDE1_W)
      ) u_div (
         .clock     (clock),
         .reset     (reset),
         .en        (en),
         .in_valid  (v5_ff),
         .num       (num1[s]),
         .den       (mom_5_ff),
         .side      (side1[s]),
         .out_valid (v1out[s]),
         .quo       (q1[s]),
         .out_side  (side1_out[s])
      );
   end

   always_comb begin
      for (int s = 0; s < NSPEC; s++) begin
         div1_side_type sd;
         logic signed [SIGMA_W-1:0] qs;
         sd = side1_out[s];
         qs = $signed({2'b00, q1[s]});
         sigma_in[s] = SIGMA_W'(sd.partial) + (sd.neg_c ? -qs : qs);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int s = 0; s < NSPEC; s++) begin
            div1_side_type sd;
            sd = side1_out[s];
            sigma_ff[s]  <= sigma_in[s];
            diff_6_ff[s] <= sd.diff;
            zero_6_ff[s] <= sd.zero;
         end
      end
   end

   // score operands: |diff| * 2^16 plus half of sigma
   always_comb begin
      for (int s = 0; s < NSPEC; s++) begin
         logic [DIFF_W-1:0] dabs;
         dabs = diff_6_ff[s][DIFF_W-1] ? DIFF_W'(-diff_6_ff[s]) : DIFF_W'(diff_6_ff[s]);
         num2_in[s] = NUM2_W'({dabs[15:0], 16'b0}) + NUM2_W'(sigma_ff[s][DEN2_W-1:1]);
         side2_in[s].bad = zero_6_ff[s] || sigma_ff[s][SIGMA_W-1] || (sigma_ff[s] == '0);
         side2_in[s].neg = diff_6_ff[s][DIFF_W-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int s = 0; s < NSPEC; s++) begin
            num2_ff[s]  <= num2_in[s];
            den2_ff[s]  <= sigma_ff[s][DEN2_W-1:0];
            side2_ff[s] <= side2_in[s];
         end
      end
   end

   for (genvar s = 0; s < NSPEC; s++) begin : g_div2
      tmnp_div #(
         .NUM_W  (NUM2_W),
         .DEN_W  (DEN2_W),
         .SIDE_W (SIDE2_W)
      ) u_div (
         .clock     (clock),
         .reset     (reset),
         .en        (en),
         .in_valid  (v7_ff),
         .num       (num2_ff[s]),
         .den       (den2_ff[s]),
         .side      (side2_ff[s]),
         .out_valid (v2out[s]),
         .quo       (q2[s]),
         .out_side  (side2_out[s])
      );
   end

   // sign and saturate to q8.8
   always_comb begin
      for (int s = 0; s < NSPEC; s++) begin
         div2_side_type sd;
         sd = side2_out[s];
         bad_in[s] = sd.bad;
         if (sd.bad) begin
            score_in[s] = '0;
         end else if (sd.neg) begin
            if (q2[s] > NUM2_W'(SCORE_MIN_MAG)) begin
               score_in[s] = SCORE_W'(-SCORE_MIN_MAG);
            end else begin
               score_in[s] = SCORE_W'(-q2[s]);
            end
         end else begin
            if (q2[s] > NUM2_W'(SCORE_MAX)) begin
               score_in[s] = SCORE_W'(SCORE_MAX);
            end else begin
               score_in[s] = SCORE_W'(q2[s]);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int s = 0; s < NSPEC; s++) begin
            score_ff[s] <= score_in[s];
         end
         bad_ff <= bad_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {score_ff[2], score_ff[1], score_ff[0]};
   assign rsp_tuser  = bad_ff;

endmodule

// ----- sv/tmnp_ln.sv -----
// two-stage ln(pt) in q.16: leading-one search and table read, then interpolation
`timescale 1ns / 1ps
module tmnp_ln (
   input  logic                              clock,
   input  logic                              en,
   input  logic [tmnp_pkg::MOM_W-1:0]        mom,
   output logic signed [tmnp_pkg::LN_W-1:0]  ln
);
   import tmnp_pkg::*;

   logic [3:0]  p_in, p_ff;
   logic [15:0] lo_in, lo_ff;
   logic [11:0] delta_in, delta_ff;
   logic [10:0] rem_in, rem_ff;
   logic [15:0] frac_sh;
   logic [3:0]  idx;
   logic signed [LN_W-1:0] ln_in, ln_ff;
   logic signed [5:0]      exp_s;
   logic signed [LN_W-1:0] exp_term;
   logic [22:0]            ip;

   always_comb begin
      p_in = '0;
      for (int i = 0; i < MOM_W; i++) begin
         if (mom[i]) begin
            p_in = 4'(i);
         end
      end
      frac_sh  = mom << (4'd15 - p_in);
      idx      = frac_sh[14:11];
      rem_in   = frac_sh[10:0];
      lo_in    = LN_TABLE[idx];
      delta_in = 12'(LN_TABLE[5'(idx) + 5'd1] - LN_TABLE[idx]);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         p_ff     <= p_in;
         lo_ff    <= lo_in;
         delta_ff <= delta_in;
         rem_ff   <= rem_in;
      end
   end

   always_comb begin
      exp_s    = $signed({2'b00, p_ff}) - 6'sd13;
      exp_term = exp_s * LN_W'(LN2_Q16);
      ip       = 23'(delta_ff) * 23'(rem_ff) + 23'd1024;
      ln_in    = exp_term + $signed({6'b0, lo_ff}) + $signed({10'b0, ip[22:11]});
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ln_ff <= ln_in;
      end
   end

   assign ln = ln_ff;

endmodule

// ----- sv/tmnp_div.sv -----
// pipelined restoring divider, one quotient bit per stage, sideband carried along
`timescale 1ns / 1ps
module tmnp_div #(
   parameter int NUM_W  = 32,
   parameter int DEN_W  = 16,
   parameter int SIDE_W = 2
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic              in_valid,
   input  logic [NUM_W-1:0]  num,
   input  logic [DEN_W-1:0]  den,
   input  logic [SIDE_W-1:0] side,
   output logic              out_valid,
   output logic [NUM_W-1:0]  quo,
   output logic [SIDE_W-1:0] out_side
);

   logic [NUM_W-1:0]  nq_ff   [NUM_W];
   logic [DEN_W-1:0]  rem_ff  [NUM_W];
   logic [DEN_W-1:0]  den_ff  [NUM_W];
   logic [SIDE_W-1:0] side_ff [NUM_W];
   logic              v_ff    [NUM_W];

   logic [NUM_W-1:0]  nq_pv   [NUM_W];
   logic [DEN_W-1:0]  rem_pv  [NUM_W];
   logic [DEN_W-1:0]  den_pv  [NUM_W];
   logic [SIDE_W-1:0] side_pv [NUM_W];
   logic              v_pv    [NUM_W];

   for (genvar i = 0; i < NUM_W; i++) begin : g_stage
      logic [DEN_W:0]    trial;
      logic [DEN_W:0]    sub;
      logic              ge;
      logic [DEN_W-1:0]  rem_in;
      logic [NUM_W-1:0]  nq_in;

      if (i == 0) begin : g_first
         assign nq_pv[i]   = num;
         assign rem_pv[i]  = '0;
         assign den_pv[i]  = den;
         assign side_pv[i] = side;
         assign v_pv[i]    = in_valid;
      end else begin : g_next
         assign nq_pv[i]   = nq_ff[i-1];
         assign rem_pv[i]  = rem_ff[i-1];
         assign den_pv[i]  = den_ff[i-1];
         assign side_pv[i] = side_ff[i-1];
         assign v_pv[i]    = v_ff[i-1];
      end

      always_comb begin
         trial  = {rem_pv[i], nq_pv[i][NUM_W-1]};
         sub    = trial - {1'b0, den_pv[i]};
         ge     = trial >= {1'b0, den_pv[i]};
         rem_in = ge ? sub[DEN_W-1:0] : trial[DEN_W-1:0];
         nq_in  = {nq_pv[i][NUM_W-2:0], ge};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[i] <= 1'b0;
         end else if (en) begin
            v_ff[i] <= v_pv[i];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            nq_ff[i]   <= nq_in;
            rem_ff[i]  <= rem_in;
            den_ff[i]  <= den_pv[i];
            side_ff[i] <= side_pv[i];
         end
      end
   end

   assign out_valid = v_ff[NUM_W-1];
   assign quo       = nq_ff[NUM_W-1];
   assign out_side  = side_ff[NUM_W-1];

endmodule
